/* design/page_frame_stack_allocator_macros.svh */
// ----------------------------------------------------------------------------
// page frame stack allocator assertion macros
// short forms for clocked implications with reset disable, used by the checker
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_STACK_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PFSA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFSA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pfsa_pkg.sv */
// ----------------------------------------------------------------------------
// pfsa_pkg
// shared constants, mode codes and item types of the page frame stack allocator
// ----------------------------------------------------------------------------
package pfsa_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 64;
    localparam int PN_W       = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W      = $clog2(MAX_PAGES);
    localparam int CNT_W      = 11;
    localparam int SAT_W      = 32;

    localparam logic [ADDR_W-1:0] ALL_ONES  = '1;
    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    localparam logic [2:0] MODE_BEGIN  = 3'd0;
    localparam logic [2:0] MODE_REGION = 3'd1;
    localparam logic [2:0] MODE_FINISH = 3'd2;
    localparam logic [2:0] MODE_ALLOC  = 3'd3;
    localparam logic [2:0] MODE_FREE   = 3'd4;

    typedef struct packed {
        logic [2:0]        mode;
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_length;
        logic              region_available;
        logic [ADDR_W-1:0] free_address;
    } pfsa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic              accepted;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  tracked_count;
        logic [SAT_W-1:0]  dropped_count;
        logic [SAT_W-1:0]  duplicate_rejects;
        logic [ADDR_W-1:0] min_page;
        logic [ADDR_W-1:0] max_page;
        logic              ready_res;
    } pfsa_res_t;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              inv;
        logic              cin;
    } pfsa_alu_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic              carry;
    } pfsa_alu_rsp_t;

endpackage

/* design/pfsa_alu.sv */
// ----------------------------------------------------------------------------
// pfsa_alu
// shared 64-bit adder: add, subtract, compare and increment for the sequencer
// ----------------------------------------------------------------------------
module pfsa_alu
    import pfsa_pkg::*;
(
    input  pfsa_alu_req_t req,
    output pfsa_alu_rsp_t rsp
);

    logic [ADDR_W-1:0] b_op;
    logic [ADDR_W:0]   total;

    // subtract is a + ~b + 1, carry out set means no borrow
    assign b_op  = req.inv ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + {{ADDR_W{1'b0}}, req.cin};

    assign rsp.sum   = total[ADDR_W-1:0];
    assign rsp.carry = total[ADDR_W];

endmodule

/* design/page_frame_stack_allocator.sv */
// ----------------------------------------------------------------------------
// page_frame_stack_allocator
// begin, finish and unused modes only execute and report; allocate adds a
// stack read; add region runs its ALU steps, then pushes its pages in turn;
// free checks the bounds, then runs a duplicate scan over the stack (one
// memory read a cycle) before the push. one item at a time, busy until the
// result strobe; the receiver cannot stall. async active-low reset clears
// counters, bounds and the kernel end register; the stack memory is not cleared
// ----------------------------------------------------------------------------
module page_frame_stack_allocator
    import pfsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pfsa_in_t          item,
    output logic              done,
    output pfsa_res_t         result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_EXEC    = 5'd1;
    localparam logic [4:0] S_R_RES   = 5'd2;
    localparam logic [4:0] S_R_END   = 5'd3;
    localparam logic [4:0] S_R_CMPE  = 5'd4;
    localparam logic [4:0] S_R_START = 5'd5;
    localparam logic [4:0] S_R_ALIGN = 5'd6;
    localparam logic [4:0] S_R_COUNT = 5'd7;
    localparam logic [4:0] S_R_TAKE  = 5'd8;
    localparam logic [4:0] S_R_DROP  = 5'd9;
    localparam logic [4:0] S_R_DADD  = 5'd10;
    localparam logic [4:0] S_R_LOW   = 5'd11;
    localparam logic [4:0] S_R_LAST  = 5'd12;
    localparam logic [4:0] S_R_HIGH  = 5'd13;
    localparam logic [4:0] S_R_PUSH  = 5'd14;
    localparam logic [4:0] S_F_LOW   = 5'd15;
    localparam logic [4:0] S_F_HIGH  = 5'd16;
    localparam logic [4:0] S_F_SCAN  = 5'd17;
    localparam logic [4:0] S_F_PUSH  = 5'd18;
    localparam logic [4:0] S_A_WAIT  = 5'd19;
    localparam logic [4:0] S_DONE    = 5'd20;

    // control state
    logic [4:0]        state_reg, state_next;
    logic [ADDR_W-1:0] ke_reg, ke_next;
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  tracked_reg, tracked_next;
    logic [SAT_W-1:0]  dropped_reg, dropped_next;
    logic [SAT_W-1:0]  dup_reg, dup_next;
    logic [ADDR_W-1:0] low_reg, low_next;
    logic [ADDR_W-1:0] high_reg, high_next;
    logic              init_reg, init_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  take_reg, take_next;

    // payload and work registers
    pfsa_in_t          in_reg, in_next;
    pfsa_res_t         res_reg, res_next;
    logic [PN_W-1:0]   resv_pn_reg, resv_pn_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [PN_W-1:0]   start_pn_reg, start_pn_next;
    logic [PN_W-1:0]   count_reg, count_next;
    logic [PN_W-1:0]   drop_reg, drop_next;
    logic [PN_W-1:0]   page_pn_reg, page_pn_next;
    logic [PN_W-1:0]   last_pn_reg, last_pn_next;
    logic [ADDR_W-1:0] granted_reg, granted_next;
    logic              acc_reg, acc_next;

    // stack memory
    logic [PN_W-1:0]   stack_mem [MAX_PAGES];
    logic [PN_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]  mem_raddr;
    logic [IDX_W-1:0]  mem_waddr;
    logic [PN_W-1:0]   mem_wdata;
    logic              mem_we;

    pfsa_alu_req_t     alu_req;
    pfsa_alu_rsp_t     alu_rsp;

    logic [CNT_W-1:0]  top_dec;
    logic [CNT_W-1:0]  room;
    logic [PN_W-1:0]   free_pn;
    logic [ADDR_W-1:0] resv_full;
    logic              scan_match;

    pfsa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    assign top_dec    = top_reg - CNT_W'(1);
    assign room       = CNT_W'(MAX_PAGES) - tracked_reg;
    assign free_pn    = in_reg.free_address[ADDR_W-1:PAGE_SHIFT];
    assign resv_full  = {resv_pn_reg, {PAGE_SHIFT{1'b0}}};
    assign scan_match = pend_reg && (rd_data_reg == free_pn);

    always_comb
    begin
        state_next    = state_reg;
        ke_next       = ke_reg;
        top_next      = top_reg;
        tracked_next  = tracked_reg;
        dropped_next  = dropped_reg;
        dup_next      = dup_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        init_next     = init_reg;
        done_next     = 1'b0;
        scan_idx_next = scan_idx_reg;
        pend_next     = pend_reg;
        take_next     = take_reg;
        in_next       = in_reg;
        res_next      = res_reg;
        resv_pn_next  = resv_pn_reg;
        end_next      = end_reg;
        start_next    = start_reg;
        start_pn_next = start_pn_reg;
        count_next    = count_reg;
        drop_next     = drop_reg;
        page_pn_next  = page_pn_reg;
        last_pn_next  = last_pn_reg;
        granted_next  = granted_reg;
        acc_next      = acc_reg;
        mem_raddr     = '0;
        mem_waddr     = top_reg[IDX_W-1:0];
        mem_wdata     = page_pn_reg;
        mem_we        = 1'b0;
        alu_req       = '0;

        if (cfg_valid && cfg_ready)
        begin
            ke_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    in_next    = item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                granted_next = ALL_ONES;
                acc_next     = 1'b0;
                state_next   = S_DONE;
                case (in_reg.mode)
                    MODE_BEGIN:
                    begin
                        top_next     = '0;
                        tracked_next = '0;
                        dropped_next = '0;
                        dup_next     = '0;
                        low_next     = '0;
                        high_next    = '0;
                        init_next    = 1'b0;
                    end
                    MODE_REGION:
                    begin
                        if (in_reg.region_available)
                        begin
                            state_next = S_R_RES;
                        end
                    end
                    MODE_FINISH:
                    begin
                        init_next = 1'b1;
                    end
                    MODE_ALLOC:
                    begin
                        if (init_reg && (top_reg != '0))
                        begin
                            mem_raddr  = top_dec[IDX_W-1:0];
                            top_next   = top_dec;
                            acc_next   = 1'b1;
                            state_next = S_A_WAIT;
                        end
                    end
                    MODE_FREE:
                    begin
                        if (init_reg && (in_reg.free_address != ALL_ONES) &&
                            ((in_reg.free_address & PAGE_MASK) == '0))
                        begin
                            state_next = S_F_LOW;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // reserved limit: kernel end rounded up to a page
            S_R_RES:
            begin
                alu_req.a = ke_reg;
                alu_req.b = PAGE_MASK;
                if (alu_rsp.carry)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    resv_pn_next = alu_rsp.sum[ADDR_W-1:PAGE_SHIFT];
                    state_next   = S_R_END;
                end
            end

            S_R_END:
            begin
                alu_req.a = in_reg.region_base;
                alu_req.b = in_reg.region_length;
                end_next  = alu_rsp.sum;
                state_next = alu_rsp.carry ? S_DONE : S_R_CMPE;
            end

            // region ends at or below the reserved limit
            S_R_CMPE:
            begin
                alu_req.a   = resv_full;
                alu_req.b   = end_reg;
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
                state_next  = alu_rsp.carry ? S_DONE : S_R_START;
            end

            S_R_START:
            begin
                alu_req.a   = in_reg.region_base;
                alu_req.b   = resv_full;
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
                start_next  = alu_rsp.carry ? in_reg.region_base : resv_full;
                state_next  = S_R_ALIGN;
            end

            S_R_ALIGN:
            begin
                alu_req.a     = start_reg;
                alu_req.b     = PAGE_MASK;
                start_pn_next = alu_rsp.sum[ADDR_W-1:PAGE_SHIFT];
                state_next    = alu_rsp.carry ? S_DONE : S_R_COUNT;
            end

            S_R_COUNT:
            begin
                alu_req.a   = ADDR_W'(end_reg[ADDR_W-1:PAGE_SHIFT]);
                alu_req.b   = ADDR_W'(start_pn_reg);
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
                count_next  = alu_rsp.sum[PN_W-1:0];
                if (!alu_rsp.carry || (alu_rsp.sum[PN_W-1:0] == '0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_R_TAKE;
                end
            end

            // take = min(count, room)
            S_R_TAKE:
            begin
                alu_req.a   = ADDR_W'(count_reg);
                alu_req.b   = ADDR_W'(room);
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
                take_next   = alu_rsp.carry ? room : count_reg[CNT_W-1:0];
                state_next  = S_R_DROP;
            end

            S_R_DROP:
            begin
                alu_req.a   = ADDR_W'(count_reg);
                alu_req.b   = ADDR_W'(take_reg);
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
                drop_next   = alu_rsp.sum[PN_W-1:0];
                state_next  = S_R_DADD;
            end

            // saturating add into the dropped counter
            S_R_DADD:
            begin
                alu_req.a = ADDR_W'(dropped_reg);
                alu_req.b = ADDR_W'(drop_reg);
                if (alu_rsp.sum[ADDR_W-1:SAT_W] != '0)
                begin
                    dropped_next = '1;
                end
                else
                begin
                    dropped_next = alu_rsp.sum[SAT_W-1:0];
                end
                state_next = (take_reg == '0) ? S_DONE : S_R_LOW;
            end

            // pages rise within a region, so only the first can lower the bound
            S_R_LOW:
            begin
                alu_req.a   = {start_pn_reg, {PAGE_SHIFT{1'b0}}};
                alu_req.b   = low_reg;
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
                if ((tracked_reg == '0) || !alu_rsp.carry)
                begin
                    low_next = {start_pn_reg, {PAGE_SHIFT{1'b0}}};
                end
                state_next = S_R_LAST;
            end

            S_R_LAST:
            begin
                alu_req.a    = ADDR_W'(start_pn_reg);
                alu_req.b    = ADDR_W'(take_reg - CNT_W'(1));
                last_pn_next = alu_rsp.sum[PN_W-1:0];
                page_pn_next = start_pn_reg;
                state_next   = S_R_HIGH;
            end

            S_R_HIGH:
            begin
                alu_req.a   = high_reg;
                alu_req.b   = {last_pn_reg, {PAGE_SHIFT{1'b0}}};
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
                if (!alu_rsp.carry)
                begin
                    high_next = {last_pn_reg, {PAGE_SHIFT{1'b0}}};
                end
                state_next = S_R_PUSH;
            end

            // one page a cycle
            S_R_PUSH:
            begin
                alu_req.a    = ADDR_W'(page_pn_reg);
                alu_req.cin  = 1'b1;
                page_pn_next = alu_rsp.sum[PN_W-1:0];
                if (top_reg < CNT_W'(MAX_PAGES))
                begin
                    mem_we   = 1'b1;
                    top_next = top_reg + CNT_W'(1);
                end
                tracked_next = tracked_reg + CNT_W'(1);
                take_next    = take_reg - CNT_W'(1);
                if (take_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end

            S_F_LOW:
            begin
                alu_req.a   = in_reg.free_address;
                alu_req.b   = low_reg;
                alu_req.inv = 1'b1;
                alu_req.cin = 1'b1;
                state_next  = alu_rsp.carry ? S_F_HIGH : S_DONE;
            end

            S_F_HIGH:
            begin
                alu_req.a     = high_reg;
                alu_req.b     = in_reg.free_address;
                alu_req.inv   = 1'b1;
                alu_req.cin   = 1'b1;
                scan_idx_next = '0;
                pend_next     = 1'b0;
                if (!alu_rsp.carry)
                begin
                    state_next = S_DONE;
                end
                else if (top_reg == '0)
                begin
                    state_next = S_F_PUSH;
                end
                else
                begin
                    state_next = S_F_SCAN;
                end
            end

            // read one entry a cycle, compare the one read the cycle before
            S_F_SCAN:
            begin
                mem_raddr = scan_idx_reg[IDX_W-1:0];
                if (scan_match)
                begin
                    if (dup_reg != '1)
                    begin
                        dup_next = dup_reg + SAT_W'(1);
                    end
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else if (pend_reg && (scan_idx_reg == top_reg))
                begin
                    pend_next  = 1'b0;
                    state_next = S_F_PUSH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                end
            end

            S_F_PUSH:
            begin
                mem_wdata = free_pn;
                if ((top_reg < tracked_reg) && (top_reg < CNT_W'(MAX_PAGES)))
                begin
                    mem_we   = 1'b1;
                    top_next = top_reg + CNT_W'(1);
                    acc_next = 1'b1;
                end
                state_next = S_DONE;
            end

            S_A_WAIT:
            begin
                granted_next = {rd_data_reg, {PAGE_SHIFT{1'b0}}};
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                res_next.granted_address   = granted_reg;
                res_next.accepted          = acc_reg;
                res_next.free_count        = top_reg;
                res_next.tracked_count     = tracked_reg;
                res_next.dropped_count     = dropped_reg;
                res_next.duplicate_rejects = dup_reg;
                res_next.min_page          = low_reg;
                res_next.max_page          = high_reg;
                res_next.ready_res         = init_reg;
                done_next                  = 1'b1;
                state_next                 = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ke_reg       <= '0;
            top_reg      <= '0;
            tracked_reg  <= '0;
            dropped_reg  <= '0;
            dup_reg      <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            init_reg     <= 1'b0;
            done_reg     <= 1'b0;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            take_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ke_reg       <= ke_next;
            top_reg      <= top_next;
            tracked_reg  <= tracked_next;
            dropped_reg  <= dropped_next;
            dup_reg      <= dup_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            init_reg     <= init_next;
            done_reg     <= done_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            take_reg     <= take_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        res_reg      <= res_next;
        resv_pn_reg  <= resv_pn_next;
        end_reg      <= end_next;
        start_reg    <= start_next;
        start_pn_reg <= start_pn_next;
        count_reg    <= count_next;
        drop_reg     <= drop_next;
        page_pn_reg  <= page_pn_next;
        last_pn_reg  <= last_pn_next;
        granted_reg  <= granted_next;
        acc_reg      <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

endmodule

/* design/pfsa_checker.sv */
// ----------------------------------------------------------------------------
// pfsa_checker
// port-level checks of the allocator handshake and result consistency
// ----------------------------------------------------------------------------
`include "page_frame_stack_allocator_macros.svh"

module pfsa_checker
    import pfsa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input pfsa_res_t result
);

    `PFSA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `PFSA_ASSERT_IMP(a_done_after_busy, done, !busy && $past(busy), "done without a busy item")
    `PFSA_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `PFSA_ASSERT_IMP(a_grant_ok, done && (result.granted_address != ALL_ONES), result.accepted, "page granted without accept")
    `PFSA_ASSERT_IMP(a_free_le_tracked, done, result.free_count <= result.tracked_count, "more free pages than tracked")

endmodule

bind page_frame_stack_allocator pfsa_checker u_pfsa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

/* bench/pfsa_frame_checker.sv */
// ----------------------------------------------------------------------------
// pfsa_frame_checker
// watches the item, result and kernel end channels of the page frame stack
// allocator, keeps its own copy of the frame stack, counters and bounds, and
// compares every done strobe field by field against the oldest prediction
// ----------------------------------------------------------------------------
module pfsa_frame_checker
    import pfsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  pfsa_in_t          item,
    input  logic              done,
    input  pfsa_res_t         result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data,
    output int                errors,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ADDR_W-1:0] kend_cfg;
    logic [PN_W-1:0]   frame_mem [MAX_PAGES];
    int unsigned       depth;
    int unsigned       tracked;
    logic [SAT_W-1:0]  dropped;
    logic [SAT_W-1:0]  dup_rejects;
    logic [ADDR_W-1:0] lo_page;
    logic [ADDR_W-1:0] hi_page;
    bit                ready;
    pfsa_res_t         awaited_reports [$];

    function automatic void clear_counters();
        depth       = 0;
        tracked     = 0;
        dropped     = '0;
        dup_rejects = '0;
        lo_page     = '0;
        hi_page     = '0;
        ready       = 0;
    endfunction

    function automatic void push_region(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] len);
        logic [ADDR_W-1:0] reserved;
        logic [ADDR_W-1:0] stop;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] count;
        logic [ADDR_W-1:0] room;
        logic [ADDR_W-1:0] take;
        logic [ADDR_W-1:0] page;
        logic [ADDR_W-1:0] sum;
        if (kend_cfg > ALL_ONES - PAGE_MASK)
            return;
        reserved = (kend_cfg + PAGE_MASK) & ~PAGE_MASK;
        stop = base + len;
        if (stop < base || stop <= reserved)
            return;
        first = (base < reserved) ? reserved : base;
        if (first > ALL_ONES - PAGE_MASK)
            return;
        first = (first + PAGE_MASK) & ~PAGE_MASK;
        stop  = stop & ~PAGE_MASK;
        if (stop <= first || stop - first <= PAGE_MASK)
            return;
        count = (stop - first) >> PAGE_SHIFT;
        room  = (tracked < MAX_PAGES) ? ADDR_W'(MAX_PAGES - tracked) : '0;
        take  = (count < room) ? count : room;
        for (int unsigned i = 0; i < take; i++)
        begin
            page = first + (ADDR_W'(i) << PAGE_SHIFT);
            if (depth < MAX_PAGES)
            begin
                frame_mem[depth] = page[ADDR_W-1:PAGE_SHIFT];
                depth++;
            end
            if (tracked == 0 || page < lo_page)
                lo_page = page;
            if (page > hi_page)
                hi_page = page;
            tracked++;
        end
        if (count > take)
        begin
            // saturating add, the excess can exceed 32 bits
            sum = ADDR_W'(dropped) + (count - take);
            if (sum < count - take || sum > ADDR_W'({SAT_W{1'b1}}))
                dropped = '1;
            else
                dropped = sum[SAT_W-1:0];
        end
    endfunction

    function automatic bit try_free(logic [ADDR_W-1:0] page);
        bit hit;
        hit = 0;
        if (!ready || page == ALL_ONES)
            return 0;
        if ((page & PAGE_MASK) != '0)
            return 0;
        if (page < lo_page || page > hi_page)
            return 0;
        for (int unsigned i = 0; i < depth && i < MAX_PAGES; i++)
            if (frame_mem[i] == page[ADDR_W-1:PAGE_SHIFT])
                hit = 1;
        if (hit)
        begin
            if (dup_rejects != '1)
                dup_rejects++;
            return 0;
        end
        if (depth >= tracked || depth >= MAX_PAGES)
            return 0;
        frame_mem[depth] = page[ADDR_W-1:PAGE_SHIFT];
        depth++;
        return 1;
    endfunction

    function automatic pfsa_res_t step_allocator(pfsa_in_t it);
        pfsa_res_t rep;
        rep.granted_address = ALL_ONES;
        rep.accepted        = 1'b0;
        case (it.mode)
            MODE_BEGIN:  clear_counters();
            MODE_REGION:
                if (it.region_available)
                    push_region(it.region_base, it.region_length);
            MODE_FINISH: ready = 1;
            MODE_ALLOC:
                if (ready && depth > 0)
                begin
                    depth--;
                    rep.granted_address = {frame_mem[depth], {PAGE_SHIFT{1'b0}}};
                    rep.accepted = 1'b1;
                end
            MODE_FREE:   rep.accepted = try_free(it.free_address);
            default: ;
        endcase
        rep.free_count        = CNT_W'(depth);
        rep.tracked_count     = CNT_W'(tracked);
        rep.dropped_count     = dropped;
        rep.duplicate_rejects = dup_rejects;
        rep.min_page          = lo_page;
        rep.max_page          = hi_page;
        rep.ready_res         = ready;
        return rep;
    endfunction

    function automatic void check_field(string name, logic [ADDR_W-1:0] exp_v,
                                        logic [ADDR_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pfsa_res_t want;
        if (!rst_n)
        begin
            kend_cfg = '0;
            clear_counters();
            awaited_reports.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kend_cfg = cfg_data;
            // the strobe belongs to the item in flight, so compare before queuing
            if (done)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("result strobe with no item outstanding");
                    errors++;
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("granted_address", want.granted_address,
                                result.granted_address);
                    check_field("accepted", want.accepted, result.accepted);
                    check_field("free_count", want.free_count, result.free_count);
                    check_field("tracked_count", want.tracked_count, result.tracked_count);
                    check_field("dropped_count", want.dropped_count, result.dropped_count);
                    check_field("duplicate_rejects", want.duplicate_rejects,
                                result.duplicate_rejects);
                    check_field("min_page", want.min_page, result.min_page);
                    check_field("max_page", want.max_page, result.max_page);
                    check_field("ready_res", want.ready_res, result.ready_res);
                end
            end
            if (start && !busy)
                awaited_reports.push_back(step_allocator(item));
        end
        outstanding = awaited_reports.size();
    end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives the page frame stack allocator with a directed pass over the region
// clipping, capacity and free rejection corners, then random init sessions of
// regions, allocations and frees; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pfsa_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    pfsa_in_t          item;
    logic              done;
    pfsa_res_t         result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data;
    int                mismatches;
    int                outstanding;

    logic [ADDR_W-1:0] granted_pages [$];
    logic [ADDR_W-1:0] kend_now;
    logic [ADDR_W-1:0] last_base;
    int                last_pages;
    int                items_sent;
    bit                quiet;

    page_frame_stack_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pfsa_frame_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // remember granted pages so that later frees hit pages really taken off
    always @(posedge clk)
    begin
        if (rst_n && done && result.accepted && result.granted_address != ALL_ONES)
            granted_pages.push_back(result.granted_address);
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // unused fields carry random content
    function automatic pfsa_in_t rand_item(logic [2:0] m);
        pfsa_in_t it;
        it.mode             = m;
        it.region_base      = rand64();
        it.region_length    = rand64();
        it.region_available = 1'($urandom_range(0, 1));
        it.free_address     = rand64();
        return it;
    endfunction

    task automatic issue(input pfsa_in_t it);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            @(negedge clk) start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (it.mode == MODE_BEGIN)
            granted_pages.delete();
    endtask

    task automatic op(input logic [2:0] m);
        issue(rand_item(m));
    endtask

    task automatic add_region(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] len,
                              input bit avail);
        pfsa_in_t it;
        it = rand_item(MODE_REGION);
        it.region_base      = base;
        it.region_length    = len;
        it.region_available = avail;
        if (avail)
        begin
            last_base  = base;
            last_pages = int'(len >> PAGE_SHIFT);
        end
        issue(it);
    endtask

    task automatic free_at(input logic [ADDR_W-1:0] addr);
        pfsa_in_t it;
        it = rand_item(MODE_FREE);
        it.free_address = addr;
        issue(it);
    endtask

    task automatic drain();
        @(negedge clk) start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_kernel_end(input logic [ADDR_W-1:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        kend_now = v;
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic random_session();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] len;
        int                pages;
        int                r;
        int                k;
        int                nops;
        bit                big;
        if ($urandom_range(0, 1))
        begin
            r = $urandom_range(0, 19);
            if (r < 5)
                set_kernel_end('0);
            else if (r < 15)
                set_kernel_end(ADDR_W'($urandom_range(0, 24'hFF_FFFF)));
            else if (r < 17)
                set_kernel_end(rand64());
            else if (r < 19)
                set_kernel_end(ALL_ONES - ADDR_W'($urandom_range(0, 'h1800)));
            else
                set_kernel_end(ALL_ONES);
        end
        op(MODE_BEGIN);
        // most sessions stay small so the duplicate scan stays short
        big = ($urandom_range(0, 9) == 0);
        repeat ($urandom_range(1, 4))
        begin
            pages = big ? $urandom_range(200, 1500) : $urandom_range(1, 24);
            base  = (kend_now & ~PAGE_MASK) + (ADDR_W'($urandom_range(0, 256)) << PAGE_SHIFT);
            if ($urandom_range(0, 3) == 0)
                base = base + ADDR_W'($urandom_range(0, 'hFFF));
            if ($urandom_range(0, 3) == 0)
                base = base - ADDR_W'('h3000);
            len = ADDR_W'(pages) << PAGE_SHIFT;
            if ($urandom_range(0, 3) == 0)
                len = len + ADDR_W'($urandom_range(0, 'hFFF));
            add_region(base, len, $urandom_range(0, 9) != 0);
        end
        if ($urandom_range(0, 7) != 0)
            op(MODE_FINISH);
        nops = $urandom_range(8, 40);
        repeat (nops)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                op(MODE_ALLOC);
            else if (r < 70)
            begin
                if (granted_pages.size() == 0)
                    op(MODE_ALLOC);
                else
                begin
                    k = $urandom_range(0, granted_pages.size() - 1);
                    base = granted_pages[k];
                    granted_pages.delete(k);
                    free_at(base);
                end
            end
            else if (r < 85)
                free_at(((last_base + PAGE_MASK) & ~PAGE_MASK)
                        + (ADDR_W'($urandom_range(0, last_pages)) << PAGE_SHIFT));
            else if (r < 90)
                free_at($urandom_range(0, 1) ? rand64() : (rand64() & ~PAGE_MASK));
            else if (r < 94)
                add_region((kend_now & ~PAGE_MASK)
                           + (ADDR_W'($urandom_range(0, 512)) << PAGE_SHIFT),
                           ADDR_W'($urandom_range(1, 8)) << PAGE_SHIFT, 1'b1);
            else if (r < 97)
                issue(rand_item(3'($urandom_range(0, 7))));
            else
                op(3'($urandom_range(0, 1)) ? MODE_FINISH : 3'($urandom_range(5, 7)));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        kend_now   = '0;
        last_base  = '0;
        last_pages = 0;
        items_sent = 0;
        quiet      = 0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // reserved limit lands mid page, rounds up to 0x101000
        set_kernel_end(64'h0000_0000_0010_0800);
        op(MODE_ALLOC);
        free_at(64'h20_0000);
        op(3'd5);
        op(3'd6);
        op(3'd7);
        op(MODE_BEGIN);
        add_region(64'h20_0000, 64'h4000, 1'b0);
        add_region(64'hFFFF_FFFF_FFFF_0000, 64'h2_0000, 1'b1);
        add_region(64'h0, 64'h1000, 1'b1);
        add_region(64'hF_0000, 64'h1_6000, 1'b1);
        add_region(64'h20_0123, 64'h3000, 1'b1);
        add_region(64'h30_0010, 64'hFF0, 1'b1);
        op(MODE_FINISH);
        op(MODE_ALLOC);
        free_at(64'h20_2000);
        free_at(64'h20_2000);
        free_at(64'h20_2001);
        free_at(ALL_ONES);
        free_at(64'h1000);
        // inside the bounds but in the gap between regions while the stack is full
        free_at(64'h15_0000);
        add_region(64'h40_0000, 64'h2000, 1'b1);

        // whole address space from page 0, fills capacity and saturates drops
        set_kernel_end('0);
        op(MODE_BEGIN);
        add_region('0, ALL_ONES, 1'b1);
        op(MODE_FINISH);
        free_at('0);
        op(MODE_ALLOC);

        // reserved limit overflows, nothing can be added
        set_kernel_end(ALL_ONES);
        op(MODE_BEGIN);
        add_region(64'h1000, 64'h1_0000, 1'b1);
        op(MODE_FINISH);
        op(MODE_ALLOC);

        while (items_sent < 600)
        begin
            quiet = (items_sent >= 500) || ($urandom_range(0, 3) == 0);
            random_session();
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(60_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/pfsa_pkg.sv
design/pfsa_alu.sv
design/page_frame_stack_allocator.sv
design/pfsa_checker.sv
bench/pfsa_frame_checker.sv
bench/tb_top.sv
